// File: rtl/max_priority_queue_linear_scan_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the max priority queue
// Shared wrappers that clock every check on clk and mute it during reset.
// ----------------------------------------------------------------------------
`ifndef MAX_PRIORITY_QUEUE_LINEAR_SCAN_ASSERT_SVH
`define MAX_PRIORITY_QUEUE_LINEAR_SCAN_ASSERT_SVH

// The condition must hold at every clock edge outside reset.
`define MPQ_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// When the antecedent holds, the consequent must hold in the next cycle.
`define MPQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/mpq_pkg.sv
// ----------------------------------------------------------------------------
// mpq_pkg
// Types, codes and sizes shared by the max priority queue modules.
// ----------------------------------------------------------------------------
`default_nettype none

package mpq_pkg;

  localparam int DEF_CAPACITY = 16;
  localparam int ID_W         = 16;
  localparam int PRIO_W       = 8;

  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [PRIO_W-1:0] prio;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  localparam logic MODE_INSERT = 1'b0;
  localparam logic MODE_REMOVE = 1'b1;

  typedef enum logic [1:0] {
    ST_INSERTED = 2'd0,
    ST_REMOVED  = 2'd1,
    ST_EMPTY    = 2'd2,
    ST_FULL     = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_SHIFT
  } state_t;

endpackage

`default_nettype wire

// File: rtl/mpq_ram.sv
// ----------------------------------------------------------------------------
// mpq_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module mpq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// File: rtl/max_priority_queue_linear_scan.sv
// ----------------------------------------------------------------------------
// max_priority_queue_linear_scan
// Bounded priority queue kept in insertion order in one RAM. A remove scans
// every entry with one comparator and then closes up the tail.
// ----------------------------------------------------------------------------
//
//   Channel   Handshake     Words
//   command   start / busy  mode, process_id, priority_req
//   result    done          status, out_id, out_priority
//
// An insert, a remove from an empty queue and an insert into a full queue
// give their result in the cycle after acceptance and leave busy low.
// A remove of one of n entries scans all n through the single RAM read port,
// then moves each entry behind the removed one down by one place; the result
// comes in the same cycle that busy falls.
// Reset empties the queue at once; the RAM contents are not cleared.
// The result strobe cannot be stalled; a new command may start in its cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module max_priority_queue_linear_scan #(
  parameter int CAPACITY = mpq_pkg::DEF_CAPACITY
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic                        mode,
  input  logic [mpq_pkg::ID_W-1:0]    process_id,
  input  logic [mpq_pkg::PRIO_W-1:0]  priority_req,
  output logic                        done,
  output logic [1:0]                  status,
  output logic [mpq_pkg::ID_W-1:0]    out_id,
  output logic [mpq_pkg::PRIO_W-1:0]  out_priority
);

  import mpq_pkg::*;

  localparam int IDX_W = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);

  state_t           state, state_next;
  logic [CNT_W-1:0] count, count_next;
  logic [IDX_W-1:0] rcv, rcv_next;
  logic [IDX_W-1:0] best_idx, best_idx_next;
  entry_t           best, best_next;

  logic             done_next;
  status_t          status_next;
  logic [ID_W-1:0]  res_id_next;
  logic [PRIO_W-1:0] res_prio_next;

  logic             rd_en, wr_en;
  logic [IDX_W-1:0] rd_addr, wr_addr;
  entry_t           rd_data, wr_data;

  logic             accept, full, empty;
  logic [CNT_W-1:0] count_m1;
  logic [IDX_W-1:0] last_idx;
  logic             take, scan_last, tail;
  logic [IDX_W-1:0] best_idx_sel;
  entry_t           best_sel;

  assign busy      = (state != S_IDLE);
  assign accept    = start && !busy;
  assign full      = (count == CNT_W'(CAPACITY));
  assign empty     = (count == '0);
  assign count_m1  = count - CNT_W'(1);
  assign last_idx  = count_m1[IDX_W-1:0];

  // The first entry seeds the scan; a later one wins only when strictly larger.
  assign take         = (rcv == '0) || (rd_data.prio > best.prio);
  assign best_idx_sel = take ? rcv : best_idx;
  assign best_sel     = take ? rd_data : best;
  assign scan_last    = (rcv == last_idx);
  assign tail         = (best_idx_sel == last_idx);

  mpq_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (CAPACITY)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept && (mode == MODE_REMOVE) && !empty) begin
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        if (scan_last) begin
          state_next = tail ? S_IDLE : S_SHIFT;
        end
      end
      S_SHIFT: begin
        if (rcv == last_idx) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    rd_en         = 1'b0;
    rd_addr       = rcv + IDX_W'(1);
    wr_en         = 1'b0;
    wr_addr       = rcv - IDX_W'(1);
    wr_data       = rd_data;
    count_next    = count;
    rcv_next      = rcv;
    best_next     = best;
    best_idx_next = best_idx;
    done_next     = 1'b0;
    status_next   = ST_INSERTED;
    res_id_next   = '0;
    res_prio_next = '0;
    case (state)
      S_IDLE: begin
        if (accept) begin
          done_next = 1'b1;
          if (mode == MODE_INSERT) begin
            if (full) begin
              status_next = ST_FULL;
            end else begin
              wr_en        = 1'b1;
              wr_addr      = count[IDX_W-1:0];
              wr_data.id   = process_id;
              wr_data.prio = priority_req;
              count_next   = count + CNT_W'(1);
              status_next  = ST_INSERTED;
            end
          end else if (empty) begin
            status_next = ST_EMPTY;
          end else begin
            done_next = 1'b0;
            rd_en     = 1'b1;
            rd_addr   = '0;
            rcv_next  = '0;
          end
        end
      end
      S_SCAN: begin
        best_next     = best_sel;
        best_idx_next = best_idx_sel;
        if (!scan_last) begin
          rd_en    = 1'b1;
          rd_addr  = rcv + IDX_W'(1);
          rcv_next = rcv + IDX_W'(1);
        end else if (tail) begin
          done_next     = 1'b1;
          status_next   = ST_REMOVED;
          res_id_next   = best_sel.id;
          res_prio_next = best_sel.prio;
          count_next    = count_m1;
        end else begin
          rd_en    = 1'b1;
          rd_addr  = best_idx_sel + IDX_W'(1);
          rcv_next = best_idx_sel + IDX_W'(1);
        end
      end
      S_SHIFT: begin
        wr_en   = 1'b1;
        wr_addr = rcv - IDX_W'(1);
        wr_data = rd_data;
        if (rcv == last_idx) begin
          done_next     = 1'b1;
          status_next   = ST_REMOVED;
          res_id_next   = best.id;
          res_prio_next = best.prio;
          count_next    = count_m1;
        end else begin
          rd_en    = 1'b1;
          rd_addr  = rcv + IDX_W'(1);
          rcv_next = rcv + IDX_W'(1);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      done  <= done_next;
    end
  end

  always_ff @(posedge clk) begin
    rcv          <= rcv_next;
    best         <= best_next;
    best_idx     <= best_idx_next;
    status       <= status_next;
    out_id       <= res_id_next;
    out_priority <= res_prio_next;
  end

endmodule

`default_nettype wire

// File: rtl/mpq_checker.sv
// ----------------------------------------------------------------------------
// mpq_checker
// Port-level checks of the max priority queue, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "max_priority_queue_linear_scan_assert.svh"

module mpq_checker (
  input wire logic                       clk,
  input wire logic                       rst,
  input wire logic                       start,
  input wire logic                       busy,
  input wire logic                       mode,
  input wire logic                       done,
  input wire logic [1:0]                 status,
  input wire logic [mpq_pkg::ID_W-1:0]   out_id,
  input wire logic [mpq_pkg::PRIO_W-1:0] out_priority
);

  import mpq_pkg::*;

  // Every accepted command either answers at once or starts a scan.
  `MPQ_ASSERT_NEXT(a_accept_answers, start && !busy, done || busy, "command neither answered nor started")
  // Only a remove may make the queue busy.
  `MPQ_ASSERT_NEXT(a_insert_idle, start && !busy && (mode == MODE_INSERT), !busy, "insert made the queue busy")
  // The result word appears only once the queue is free again.
  `MPQ_ASSERT_ALWAYS(a_done_free, !done || !busy, "result while busy")
  // Words other than a removal carry no entry.
  `MPQ_ASSERT_ALWAYS(a_zero_payload, !done || (status == ST_REMOVED) || ((out_id == '0) && (out_priority == '0)), "payload on a non-removal")

endmodule

bind max_priority_queue_linear_scan mpq_checker u_mpq_checker (
  .clk          (clk),
  .rst          (rst),
  .start        (start),
  .busy         (busy),
  .mode         (mode),
  .done         (done),
  .status       (status),
  .out_id       (out_id),
  .out_priority (out_priority)
);

`default_nettype wire
